// ----- sv/sheet_diffusion_3d_macros.svh -----
// assertion macros for the sheet diffusion block
`ifndef SHEET_DIFFUSION_3D_MACROS_SVH
`define SHEET_DIFFUSION_3D_MACROS_SVH
`ifndef SYNTHESIS
`define SD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define SD_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define SD_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define SD_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- sv/sd3_pkg.sv -----
// ---------------------------------------------------------------------------
// sd3_pkg
// shared types, constants, rounding and saturation helpers of the sheet diffusion block
// ---------------------------------------------------------------------------
package sd3_pkg;

  localparam int DefMaxX = 32;
  localparam int DefMaxY = 32;
  localparam int DefMaxZ = 32;
  localparam int ONE_Q16 = 65536;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_C_NORM = 3'd3;
  localparam logic [2:0] REG_DT     = 3'd4;
  localparam logic [2:0] REG_ITER   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP,
    ST_ITER,
    ST_FETCH,
    ST_WAIT,
    ST_MATH,
    ST_WRITE,
    ST_NEXT
  } state_t;

  // sequencer command to the shared alu
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_MULADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic            go;
    alu_op_t         op;
    logic signed [47:0] a;
    logic signed [47:0] b;
    logic signed [63:0] acc;
    logic [4:0]      shift;
  } alu_req_t;

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input logic [4:0] s);
    logic signed [63:0] t;
    begin
      t = v + (64'sd1 <<< (s - 5'd1));
      rnd_shr = t >>> s;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- sv/sheet_diffusion_3d.sv -----
// response: load, unused kinds and out-of-range reads fill the response register on
//   acceptance, an in-range read after ST_READ and ST_RESP; a run does a flux pass
//   and an update pass per iteration over the size box (serial reads, shared alu)
// throughput: one request at a time, stall high while a request is at work or its response waits
// reset: synchronous active-low, config returns to 32,32,32,3277,7864,12;
//   voxel memories are not cleared
// ---------------------------------------------------------------------------
// sheet_diffusion_3d
// explicit anisotropic diffusion over a voxel volume with a shared alu
// ---------------------------------------------------------------------------
`include "sheet_diffusion_3d_macros.svh"
module sheet_diffusion_3d #(
  parameter int MAX_X = sd3_pkg::DefMaxX,
  parameter int MAX_Y = sd3_pkg::DefMaxY,
  parameter int MAX_Z = sd3_pkg::DefMaxZ
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [4:0]         in_x,
  input  logic [4:0]         in_y,
  input  logic [4:0]         in_z,
  input  logic signed [31:0] in_value,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [16:0]        in_sheet,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic               out_op_done
);
  import sd3_pkg::*;

  localparam int XW = $clog2(MAX_X);
  localparam int YW = $clog2(MAX_Y);
  localparam int ZW = $clog2(MAX_Z);
  localparam int AW = XW + YW + ZW;
  localparam int DEPTH = 1 << AW;
  localparam int CW = XW + 1;
  localparam int CYW = YW + 1;
  localparam int CZW = ZW + 1;

  // memories
  logic signed [31:0] vox_mem [DEPTH];
  logic [47:0]        nrm_mem [DEPTH];
  logic [16:0]        sht_mem [DEPTH];
  logic signed [31:0] fx_mem  [DEPTH];
  logic signed [31:0] fy_mem  [DEPTH];
  logic signed [31:0] fz_mem  [DEPTH];

  logic [AW-1:0]      rd_addr;
  logic signed [31:0] vox_q, fx_q, fy_q, fz_q;
  logic [47:0]        nrm_q;
  logic [16:0]        sht_q;
  logic               vox_we, flux_we, ld_we;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] vox_wd, fx_wd, fy_wd, fz_wd;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      nrm_mem[wr_addr] <= {in_normal_x, in_normal_y, in_normal_z};
      sht_mem[wr_addr] <= in_sheet;
    end
    if (vox_we) vox_mem[wr_addr] <= vox_wd;
    if (flux_we) begin
      fx_mem[wr_addr] <= fx_wd;
      fy_mem[wr_addr] <= fy_wd;
      fz_mem[wr_addr] <= fz_wd;
    end
    vox_q <= vox_mem[rd_addr];
    nrm_q <= nrm_mem[rd_addr];
    sht_q <= sht_mem[rd_addr];
    fx_q  <= fx_mem[rd_addr];
    fy_q  <= fy_mem[rd_addr];
    fz_q  <= fz_mem[rd_addr];
  end

  // configuration
  logic [5:0]  size_x_r, size_y_r, size_z_r;
  logic [16:0] c_norm_r, dt_r;
  logic [7:0]  iter_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r   <= 6'd32;
      size_y_r   <= 6'd32;
      size_z_r   <= 6'd32;
      c_norm_r   <= 17'd3277;
      dt_r       <= 17'd7864;
      iter_cfg_r <= 8'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r   <= cfg_data[5:0];
        REG_SIZE_Y: size_y_r   <= cfg_data[5:0];
        REG_SIZE_Z: size_z_r   <= cfg_data[5:0];
        REG_C_NORM: c_norm_r   <= cfg_data;
        REG_DT:     dt_r       <= cfg_data;
        REG_ITER:   iter_cfg_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [8:0] eff(input logic [5:0] v, input int mx);
    begin
      if (v == 6'd0) eff = 9'd1;
      else if (int'(v) > mx) eff = 9'(mx);
      else eff = {3'd0, v};
    end
  endfunction

  logic [8:0] sx, sy, sz;
  logic signed [47:0] cn, step;
  assign sx = eff(size_x_r, MAX_X);
  assign sy = eff(size_y_r, MAX_Y);
  assign sz = eff(size_z_r, MAX_Z);
  assign cn   = (c_norm_r > 17'd65536) ? 48'sd65536 : 48'(c_norm_r);
  assign step = (dt_r > 17'd65536) ? 48'sd65536 : 48'(dt_r);

  // shared alu
  alu_req_t           req;
  logic signed [63:0] alu_res;
  logic               alu_vld;

  sd3_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .res     (alu_res),
    .res_vld (alu_vld)
  );

  // sequencer
  state_t state_r, state_nxt;
  logic [CW-1:0]  cx_r, cx_nxt;
  logic [CYW-1:0] cy_r, cy_nxt;
  logic [CZW-1:0] cz_r, cz_nxt;
  logic [7:0]     it_r, it_nxt;
  logic           pass_r, pass_nxt;
  logic [4:0]     sub_r, sub_nxt;
  logic signed [31:0] rv_r, rv_nxt;
  logic           done_r, done_nxt;
  logic           ov_r, ov_nxt;
  logic [4:0]     rx_r, ry_r, rz_r;
  logic signed [63:0] t_r [12];
  logic signed [63:0] t_nxt [12];
  logic           acc_in;
  logic           in_range;
  logic [AW-1:0]  in_addr;

  function automatic logic [AW-1:0] adr(input int x, input int y, input int z);
    begin
      adr = {z[ZW-1:0], y[YW-1:0], x[XW-1:0]};
    end
  endfunction

  assign acc_in   = in_valid && !in_stall;
  assign in_range = (int'(in_x) < MAX_X) && (int'(in_y) < MAX_Y) && (int'(in_z) < MAX_Z);
  assign in_addr  = adr(int'(in_x), int'(in_y), int'(in_z));
  assign in_stall = (state_r != ST_IDLE) || ov_r;

  int xi, yi, zi, xm, xp, ym, yp, zm, zp;
  always_comb begin
    xi = int'(cx_r); yi = int'(cy_r); zi = int'(cz_r);
    xm = (xi == 0) ? 0 : xi - 1;
    xp = (xi + 1 >= int'(sx)) ? int'(sx) - 1 : xi + 1;
    ym = (yi == 0) ? 0 : yi - 1;
    yp = (yi + 1 >= int'(sy)) ? int'(sy) - 1 : yi + 1;
    zm = (zi == 0) ? 0 : zi - 1;
    zp = (zi + 1 >= int'(sz)) ? int'(sz) - 1 : zi + 1;
  end

  // fetch order: center, x+, x-, y+, y-, z+, z-
  logic [2:0] fi_r, fi_nxt;
  always_comb begin
    unique case (fi_r)
      3'd0: rd_addr = adr(xi, yi, zi);
      3'd1: rd_addr = adr(xp, yi, zi);
      3'd2: rd_addr = adr(xm, yi, zi);
      3'd3: rd_addr = adr(xi, yp, zi);
      3'd4: rd_addr = adr(xi, ym, zi);
      3'd5: rd_addr = adr(xi, yi, zp);
      3'd6: rd_addr = adr(xi, yi, zm);
      default: rd_addr = adr(xi, yi, zi);
    endcase
    if (state_r == ST_READ) rd_addr = adr(int'(rx_r), int'(ry_r), int'(rz_r));
  end

  logic signed [47:0] nx, ny, nz;
  assign nx = 48'(signed'(t_r[8][47:32]));
  assign ny = 48'(signed'(t_r[8][31:16]));
  assign nz = 48'(signed'(t_r[8][15:0]));

  // t slots: 0 center u, 1..6 neighbor values or fluxes, 7 sheet, 8 normal,
  // 9..11 gradients/results
  logic signed [63:0] fd;
  always_comb begin
    state_nxt = state_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r;
    it_nxt = it_r; pass_nxt = pass_r; sub_nxt = sub_r; fi_nxt = fi_r;
    rv_nxt = rv_r; done_nxt = done_r; ov_nxt = ov_r;
    for (int i = 0; i < 12; i++) t_nxt[i] = t_r[i];
    req = '{go: 1'b0, op: ALU_MUL, a: '0, b: '0, acc: '0, shift: 5'd0};
    ld_we = 1'b0; vox_we = 1'b0; flux_we = 1'b0;
    wr_addr = adr(xi, yi, zi);
    vox_wd = in_value; fx_wd = '0; fy_wd = '0; fz_wd = '0;
    fd = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          rv_nxt = '0;
          done_nxt = 1'b1;
          priority if (in_kind == KIND_LOAD) begin
            ld_we = in_range; vox_we = in_range; wr_addr = in_addr;
            ov_nxt = 1'b1;
          end else if (in_kind == KIND_RUN) begin
            it_nxt = iter_cfg_r;
            state_nxt = ST_ITER;
          end else if (in_kind == KIND_READ) begin
            if (in_range) state_nxt = ST_READ;
            else ov_nxt = 1'b1;
          end else begin
            done_nxt = 1'b0;
            ov_nxt = 1'b1;
          end
        end
      end
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: begin
        rv_nxt = vox_q;
        ov_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_ITER: begin
        cx_nxt = '0; cy_nxt = '0; cz_nxt = '0; pass_nxt = 1'b0; fi_nxt = '0;
        if (it_r == 8'd0) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        // capture data of address fi_r
        if (pass_r == 1'b0) begin
          t_nxt[fi_r] = 64'(vox_q);
          if (fi_r == 3'd0) begin
            t_nxt[7] = 64'(sht_q > 17'd65536 ? 17'd65536 : sht_q);
            t_nxt[8] = 64'(nrm_q);
          end
        end else begin
          priority case (fi_r)
            3'd0: t_nxt[0] = 64'(vox_q);
            3'd1, 3'd2: t_nxt[fi_r] = 64'(fx_q);
            3'd3, 3'd4: t_nxt[fi_r] = 64'(fy_q);
            default: t_nxt[fi_r] = 64'(fz_q);
          endcase
        end
        if (fi_r == 3'd6) begin
          fi_nxt = '0; sub_nxt = '0; state_nxt = ST_MATH;
        end else begin
          fi_nxt = fi_r + 3'd1; state_nxt = ST_FETCH;
        end
      end
      ST_MATH: begin
        // even sub steps take results and issue, odd ones wait on the alu's product and result registers
        sub_nxt = sub_r + 5'd1;
        if (pass_r == 1'b0) begin
          unique case (sub_r)
            5'd0: begin
              req = '{1'b1, ALU_SUB, 48'(t_r[1]), 48'(t_r[2]), '0, 5'd1};
            end
            5'd2: begin
              t_nxt[9] = alu_res;
              req = '{1'b1, ALU_SUB, 48'(t_r[3]), 48'(t_r[4]), '0, 5'd1};
            end
            5'd4: begin
              t_nxt[10] = alu_res;
              req = '{1'b1, ALU_SUB, 48'(t_r[5]), 48'(t_r[6]), '0, 5'd1};
            end
            5'd6: begin
              t_nxt[11] = alu_res;
              // (1-cn)*sheet
              req = '{1'b1, ALU_MUL, 48'sd65536 - cn, 48'(t_r[7]), '0, 5'd16};
            end
            5'd8: begin
              t_nxt[7] = alu_res; // beta
              req = '{1'b1, ALU_MUL, 48'(t_r[9]), nx, '0, 5'd0};
            end
            5'd10: begin
              t_nxt[1] = alu_res;
              req = '{1'b1, ALU_MULADD, 48'(t_r[10]), ny, alu_res, 5'd0};
            end
            5'd12: begin
              t_nxt[1] = alu_res;
              req = '{1'b1, ALU_MULADD, 48'(t_r[11]), nz, alu_res, 5'd0};
            end
            5'd14: begin
              // ndg rounding via multiply by one
              req = '{1'b1, ALU_MUL, 48'(alu_res), 48'sd1, '0, 5'd14};
            end
            5'd16: begin
              req = '{1'b1, ALU_MUL, 48'(alu_res), 48'(t_r[7]), '0, 5'd16};
            end
            5'd18: begin
              t_nxt[2] = alu_res; // bn
              req = '{1'b1, ALU_MUL, 48'(alu_res), nx, '0, 5'd14};
            end
            5'd20: begin
              t_nxt[3] = alu_res;
              req = '{1'b1, ALU_MUL, 48'(t_r[2]), ny, '0, 5'd14};
            end
            5'd22: begin
              t_nxt[4] = alu_res;
              req = '{1'b1, ALU_MUL, 48'(t_r[2]), nz, '0, 5'd14};
            end
            5'd24: begin
              t_nxt[5] = alu_res;
              req = '{1'b1, ALU_MUL, 48'(t_r[9]), cn + 48'(t_r[7]), '0, 5'd16};
            end
            5'd26: begin
              t_nxt[9] = alu_res - t_r[3];
              req = '{1'b1, ALU_MUL, 48'(t_r[10]), cn + 48'(t_r[7]), '0, 5'd16};
            end
            5'd28: begin
              t_nxt[10] = alu_res - t_r[4];
              req = '{1'b1, ALU_MUL, 48'(t_r[11]), cn + 48'(t_r[7]), '0, 5'd16};
            end
            5'd30: begin
              t_nxt[11] = alu_res - t_r[5];
              state_nxt = ST_WRITE;
            end
            default: ;
          endcase
        end else begin
          unique case (sub_r)
            5'd0: req = '{1'b1, ALU_SUB, 48'(t_r[1]), 48'(t_r[2]), '0, 5'd1};
            5'd2: begin
              t_nxt[9] = alu_res;
              req = '{1'b1, ALU_SUB, 48'(t_r[3]), 48'(t_r[4]), '0, 5'd1};
            end
            5'd4: begin
              t_nxt[9] = t_r[9] + alu_res;
              req = '{1'b1, ALU_SUB, 48'(t_r[5]), 48'(t_r[6]), '0, 5'd1};
            end
            5'd6: begin
              fd = t_r[9] + alu_res;
              req = '{1'b1, ALU_MUL, 48'(fd), step, '0, 5'd16};
            end
            5'd8: begin
              t_nxt[9] = t_r[0] + alu_res;
              state_nxt = ST_WRITE;
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        if (pass_r == 1'b0) begin
          flux_we = 1'b1;
          fx_wd = sat32(t_r[9]);
          fy_wd = sat32(t_r[10]);
          fz_wd = sat32(t_r[11]);
        end else begin
          vox_we = 1'b1;
          vox_wd = sat32(t_r[9]);
        end
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        fi_nxt = '0;
        state_nxt = ST_FETCH;
        if (32'(cx_r) + 32'd1 < 32'(sx)) cx_nxt = cx_r + 1'b1;
        else begin
          cx_nxt = '0;
          if (32'(cy_r) + 32'd1 < 32'(sy)) cy_nxt = cy_r + 1'b1;
          else begin
            cy_nxt = '0;
            if (32'(cz_r) + 32'd1 < 32'(sz)) cz_nxt = cz_r + 1'b1;
            else begin
              cz_nxt = '0;
              if (pass_r == 1'b0) pass_nxt = 1'b1;
              else begin
                pass_nxt = 1'b0;
                it_nxt = it_r - 8'd1;
                state_nxt = ST_ITER;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      fi_r    <= '0;
      sub_r   <= '0;
      pass_r  <= 1'b0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      fi_r    <= fi_nxt;
      sub_r   <= sub_nxt;
      pass_r  <= pass_nxt;
      it_r    <= it_nxt;
    end
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    rv_r <= rv_nxt; done_r <= done_nxt;
    for (int i = 0; i < 12; i++) t_r[i] <= t_nxt[i];
    if (acc_in) begin
      rx_r <= in_x; ry_r <= in_y; rz_r <= in_z;
    end
  end

  assign out_valid      = ov_r;
  assign out_read_value = rv_r;
  assign out_op_done    = done_r;

  `SD_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != ST_IDLE, in_stall)
  `SD_ASSERT_NXT(a_resp_held, clk, rst_n, ov_r && out_stall, ov_r && $stable(rv_r))
  `SD_ASSERT_NXT(a_read_resp, clk, rst_n, state_r == ST_RESP, ov_r && state_r == ST_IDLE)
  `SD_ASSERT_IMP(a_no_we_idle_math, clk, rst_n, state_r == ST_MATH, !vox_we && !flux_we)
  `SD_ASSERT_IMP(a_alu_ready, clk, rst_n, state_r == ST_MATH && sub_r != 5'd0 && !sub_r[0], alu_vld)

endmodule

// ----- sv/sd3_alu.sv -----
// ---------------------------------------------------------------------------
// sd3_alu
// shared multiply, subtract, accumulate and rounding unit, one operation per request
// ---------------------------------------------------------------------------
module sd3_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  sd3_pkg::alu_req_t   req,
  output logic signed [63:0]  res,
  output logic                res_vld
);
  import sd3_pkg::*;

  logic signed [63:0] prod_r, prod_nxt;
  logic signed [63:0] acc_r;
  alu_op_t            op_r;
  logic [4:0]         sh_r;
  logic               v1_r, v2_r;
  logic signed [63:0] res_r, res_nxt;
  logic signed [17:0] mb;

  // stage one: 48x18 product or difference, stage two: add and round
  // the narrow operand of a product always sits in b
  always_comb begin
    mb = req.b[17:0];
    prod_nxt = req.a * mb;
    if (req.op == ALU_SUB) prod_nxt = req.a - req.b;
  end

  always_comb begin
    unique case (op_r)
      ALU_MUL:    res_nxt = (sh_r == 5'd0) ? prod_r : rnd_shr(prod_r, sh_r);
      ALU_MULADD: res_nxt = acc_r + prod_r;
      ALU_SUB:    res_nxt = rnd_shr(prod_r, sh_r);
      default:    res_nxt = prod_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.go;
      v2_r <= v1_r;
    end
    prod_r <= prod_nxt;
    acc_r  <= req.acc;
    op_r   <= req.op;
    sh_r   <= req.shift;
    res_r  <= res_nxt;
  end

  assign res     = res_r;
  assign res_vld = v2_r;

endmodule
